// File: rtl/core/lfu_pkg.sv
package lfu_pkg;

    localparam int FC_W        = 5;
    localparam int FRAME_IDX_W = 4;
    localparam int M_DATA_W    = 8;

    localparam logic [FC_W-1:0] FC_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_WRITE
    } lfu_state_t;

endpackage

// File: rtl/core/lfu_page_replacement_top.sv
// Each reference is handled in turn: the scan steps through READ then CMP for each frame in use,
// from frame zero upwards, and a hit ends it early; WRITE then updates the frame and the result.
// A new reference is taken only once the previous one has left WRITE, which can stall on m_tready;
// the scan reads one frame at a time through a single registered port and one compare unit.
// Reset (aresetn low, synchronous): all frames empty, logical clock zero, frame count 16.
// A frame count write clears every frame at once and restarts the logical clock.
module lfu_page_replacement_top
    import lfu_pkg::*;
#(
    parameter int MAX_FRAME_SLOTS = 16,
    parameter int PAGE_BITS       = 16,
    parameter int COUNTER_BITS    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [FC_W-1:0]                     cfg_data,   // frame_count
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0]      s_tdata,    // page_number
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [M_DATA_W-1:0]                 m_tdata,    // frame_index, zero fill
    output logic                                m_tuser     // hit
);

    localparam int IDX_W = (MAX_FRAME_SLOTS > 1) ? $clog2(MAX_FRAME_SLOTS) : 1;
    localparam int LIM_W = ($clog2(MAX_FRAME_SLOTS + 1) > FC_W) ?
                           $clog2(MAX_FRAME_SLOTS + 1) : FC_W;

    lfu_state_t state_reg, state_next;

    logic [FC_W-1:0]            fc_reg, fc_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [PAGE_BITS-1:0]       page_reg, page_next;
    logic [COUNTER_BITS-1:0]    clock_reg, clock_next;
    logic [MAX_FRAME_SLOTS-1:0] valid_reg;
    logic                       found_empty_reg, found_empty_next;
    logic [IDX_W-1:0]           empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]           best_idx_reg, best_idx_next;
    logic [COUNTER_BITS-1:0]    best_cnt_reg, best_cnt_next;
    logic [COUNTER_BITS-1:0]    best_time_reg, best_time_next;
    logic                       hit_reg, hit_next;
    logic [IDX_W-1:0]           sel_idx_reg, sel_idx_next;
    logic [COUNTER_BITS-1:0]    hit_cnt_reg, hit_cnt_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic                       m_hit_reg, m_hit_next;
    logic [FRAME_IDX_W-1:0]     m_idx_reg, m_idx_next;

    // Frame stores: one write port and one registered read port each.
    logic [PAGE_BITS-1:0]       page_mem [MAX_FRAME_SLOTS];
    logic [COUNTER_BITS-1:0]    cnt_mem  [MAX_FRAME_SLOTS];
    logic [COUNTER_BITS-1:0]    time_mem [MAX_FRAME_SLOTS];
    logic [PAGE_BITS-1:0]       rd_page_reg;
    logic [COUNTER_BITS-1:0]    rd_cnt_reg;
    logic [COUNTER_BITS-1:0]    rd_time_reg;

    logic [LIM_W-1:0]           fc_ext;
    logic [LIM_W-1:0]           lim;
    logic [IDX_W-1:0]           last_idx;
    logic                       vld_cur;
    logic                       match;
    logic                       is_last;
    logic                       better;
    logic                       out_free;
    logic                       s_accept;
    logic                       cfg_accept;
    logic                       commit;
    logic [COUNTER_BITS-1:0]    wr_cnt;

    // A stored count of zero acts as one frame; anything above the slot count is clamped.
    always_comb begin
        fc_ext = LIM_W'(fc_reg);
        if (fc_ext == '0) begin
            lim = LIM_W'(1);
        end else if (fc_ext > LIM_W'(MAX_FRAME_SLOTS)) begin
            lim = LIM_W'(MAX_FRAME_SLOTS);
        end else begin
            lim = fc_ext;
        end
    end
    assign last_idx = IDX_W'(lim - LIM_W'(1));

    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign commit     = (state_reg == ST_WRITE) && out_free;

    // The shared compare unit: page match plus count/timestamp ordering for the victim.
    assign vld_cur = valid_reg[idx_reg];
    assign match   = vld_cur && (rd_page_reg == page_reg);
    assign is_last = (idx_reg == last_idx);
    assign better  = (idx_reg == '0) || (rd_cnt_reg < best_cnt_reg) ||
                     ((rd_cnt_reg == best_cnt_reg) && (rd_time_reg < best_time_reg));

    assign wr_cnt = hit_reg ? ((&hit_cnt_reg) ? hit_cnt_reg : hit_cnt_reg + 1'b1)
                            : COUNTER_BITS'(1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (match || is_last) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        fc_next          = fc_reg;
        idx_next         = idx_reg;
        page_next        = page_reg;
        clock_next       = clock_reg;
        found_empty_next = found_empty_reg;
        empty_idx_next   = empty_idx_reg;
        best_idx_next    = best_idx_reg;
        best_cnt_next    = best_cnt_reg;
        best_time_next   = best_time_reg;
        hit_next         = hit_reg;
        sel_idx_next     = sel_idx_reg;
        hit_cnt_next     = hit_cnt_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_hit_next       = m_hit_reg;
        m_idx_next       = m_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cfg_accept) begin
                    fc_next    = cfg_data;
                    clock_next = '0;
                end else if (s_accept) begin
                    page_next        = s_tdata[PAGE_BITS-1:0];
                    clock_next       = (&clock_reg) ? clock_reg : clock_reg + 1'b1;
                    idx_next         = '0;
                    found_empty_next = 1'b0;
                    hit_next         = 1'b0;
                end
            end
            ST_CMP: begin
                if (match) begin
                    hit_next     = 1'b1;
                    sel_idx_next = idx_reg;
                    hit_cnt_next = rd_cnt_reg;
                end else begin
                    if (!vld_cur && !found_empty_reg) begin
                        found_empty_next = 1'b1;
                        empty_idx_next   = idx_reg;
                    end
                    // The victim is only taken when every frame in use is valid.
                    if (better) begin
                        best_idx_next  = idx_reg;
                        best_cnt_next  = rd_cnt_reg;
                        best_time_next = rd_time_reg;
                    end
                    if (is_last) begin
                        hit_next = 1'b0;
                        if (found_empty_reg) begin
                            sel_idx_next = empty_idx_reg;
                        end else if (!vld_cur || better) begin
                            sel_idx_next = idx_reg;
                        end else begin
                            sel_idx_next = best_idx_reg;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_hit_next    = hit_reg;
                    m_idx_next    = FRAME_IDX_W'(sel_idx_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fc_reg       <= FC_RESET;
            clock_reg    <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fc_reg       <= fc_next;
            clock_reg    <= clock_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_accept) begin
                valid_reg <= '0;
            end else if (commit) begin
                valid_reg[sel_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        page_reg        <= page_next;
        found_empty_reg <= found_empty_next;
        empty_idx_reg   <= empty_idx_next;
        best_idx_reg    <= best_idx_next;
        best_cnt_reg    <= best_cnt_next;
        best_time_reg   <= best_time_next;
        hit_reg         <= hit_next;
        sel_idx_reg     <= sel_idx_next;
        hit_cnt_reg     <= hit_cnt_next;
        m_hit_reg       <= m_hit_next;
        m_idx_reg       <= m_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_page_reg <= page_mem[idx_reg];
            rd_cnt_reg  <= cnt_mem[idx_reg];
            rd_time_reg <= time_mem[idx_reg];
        end
        if (commit) begin
            page_mem[sel_idx_reg] <= page_reg;
            cnt_mem[sel_idx_reg]  <= wr_cnt;
            time_mem[sel_idx_reg] <= clock_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = M_DATA_W'(m_idx_reg);

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_READ) && (idx_reg == '0))
        else $error("accepted reference did not start a scan at frame zero");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (idx_reg <= last_idx))
        else $error("scan index beyond the frames in use");

    a_commit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> valid_reg[$past(sel_idx_reg)])
        else $error("written frame not marked valid");

    a_clock_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (clock_reg != '0))
        else $error("logical clock still zero after a reference");

    a_result_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid_reg && (m_tuser == $past(hit_reg)))
        else $error("result not presented after frame update");

endmodule
